### rtl/set_assoc_cache_lru_hit_counter_assert.svh
// Assertion macros for the cache block checker.
`ifndef SET_ASSOC_CACHE_LRU_HIT_COUNTER_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_HIT_COUNTER_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define SACL_AST_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define SACL_AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked while reset is applied.
`define SACL_AST_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sacl_pkg.sv
`timescale 1ns / 1ps
package sacl_pkg;

  function automatic int floor_log2(input int n);
    int p;
    int v;
    p = 0;
    v = n;
    while (v > 1) begin
      v = v >> 1;
      p = p + 1;
    end
    return p;
  endfunction

  localparam int WAYS        = 4;
  localparam int SETS        = 64;
  localparam int BLOCK_BYTES = 16;
  localparam int ADDR_W      = 32;
  localparam int CNT_W       = 32;
  localparam int USED_W      = 2;

  localparam int OFF_BITS  = floor_log2(BLOCK_BYTES);
  localparam int IDX_BITS  = floor_log2(SETS);
  localparam int TAG_SHIFT = OFF_BITS + IDX_BITS;
  localparam int TAG_W     = ADDR_W - TAG_SHIFT;
  localparam int IDX_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_W    = WAY_W;

  localparam logic [ADDR_W-1:0] SET_MASK = ADDR_W'((64'd1 << IDX_BITS) - 64'd1);
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [WAY_W-1:0]  way_t;
  typedef logic [RANK_W-1:0] rank_t;

  // One set: tags, valid bits and LRU ranks of all ways (rank 0 = most recent).
  typedef struct packed {
    tag_t  [WAYS-1:0] tag;
    logic  [WAYS-1:0] vld;
    rank_t [WAYS-1:0] rank;
  } row_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

endpackage

### rtl/sacl_in_if.sv
`timescale 1ns / 1ps
interface sacl_in_if import sacl_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

### rtl/sacl_out_if.sv
`timescale 1ns / 1ps
interface sacl_out_if import sacl_pkg::*;;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [USED_W-1:0] way_used;
  logic              evicted;
  logic [CNT_W-1:0]  hit_total;
  logic [CNT_W-1:0]  access_total;

  modport source (output valid, output hit, output way_used, output evicted,
                  output hit_total, output access_total, input ready);
  modport sink   (input valid, input hit, input way_used, input evicted,
                  input hit_total, input access_total, output ready);
endinterface

### rtl/set_assoc_cache_lru_hit_counter.sv
// The set is read into rd_row_r at item accept; the lookup result is registered,
// with the set write-back, when ST_LOOKUP fires, which waits while an untaken
// result is held. Items are not overlapped: a new item is taken only in ST_IDLE,
// so only one item is in flight.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low) clears control, counters and per-set init
// flags; an uninitialized set reads as all ways invalid, rank zero.
`timescale 1ns / 1ps
module set_assoc_cache_lru_hit_counter import sacl_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  sacl_in_if.sink         in_ch,
  sacl_out_if.source      out_ch
);

  state_t st_r, st_nxt;
  logic   fire;

  // set RAM and per-set init flags
  row_t            mem [SETS];
  row_t            rd_row_r;
  logic [SETS-1:0] row_init_r;
  logic            init_r;
  tag_t            tag_r;
  idx_t            idx_r;
  logic            acc;
  idx_t            rd_idx;

  row_t  cur, upd;
  logic  hit_c, evict_c, was_valid;
  way_t  found, inval, best, victim;
  logic  found_ok, inval_ok;
  rank_t old_rank;

  logic [CNT_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0] acc_cnt_r, acc_cnt_nxt;

  logic              out_valid_r;
  logic              hit_r, evicted_r;
  logic [USED_W-1:0] way_used_r;

  assign acc    = in_ch.valid && in_ch.ready;
  assign rd_idx = IDX_W'((in_ch.address >> OFF_BITS) & SET_MASK);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:   if (in_ch.valid) st_nxt = ST_LOOKUP;
      ST_LOOKUP: if (fire) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready = 1'b0;
    fire        = 1'b0;
    case (st_r)
      ST_IDLE:   in_ch.ready = 1'b1;
      ST_LOOKUP: fire = !out_valid_r || out_ch.ready;
      default: begin
        in_ch.ready = 1'b0;
        fire        = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) mem[idx_r] <= upd;
    if (acc) begin
      rd_row_r <= mem[rd_idx];
      init_r   <= row_init_r[rd_idx];
      idx_r    <= rd_idx;
      tag_r    <= TAG_W'(in_ch.address >> TAG_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_init_r <= '0;
    end else if (fire) begin
      row_init_r[idx_r] <= 1'b1;
    end
  end

  // lookup and LRU update
  always_comb begin
    cur     = rd_row_r;
    if (!init_r) begin
      cur.vld  = '0;
      cur.rank = '0;
    end
    found    = '0;
    found_ok = 1'b0;
    inval    = '0;
    inval_ok = 1'b0;
    best     = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (cur.vld[w]) begin
        if (!found_ok && cur.tag[w] == tag_r) begin
          found    = way_t'(w);
          found_ok = 1'b1;
        end
      end else if (!inval_ok) begin
        inval    = way_t'(w);
        inval_ok = 1'b1;
      end
      if (cur.rank[w] > cur.rank[best]) best = way_t'(w);
    end

    hit_c     = found_ok;
    evict_c   = !found_ok && !inval_ok;
    was_valid = hit_c || evict_c;
    victim    = hit_c ? found : (inval_ok ? inval : best);
    old_rank  = cur.rank[victim];

    upd = cur;
    for (int v = 0; v < WAYS; v++) begin
      if (way_t'(v) != victim && cur.vld[v] && (!was_valid || cur.rank[v] < old_rank))
        upd.rank[v] = cur.rank[v] + rank_t'(1);
    end
    upd.rank[victim] = '0;
    upd.vld[victim]  = 1'b1;
    if (!hit_c) upd.tag[victim] = tag_r;

    hit_cnt_nxt = (hit_c && hit_cnt_r != CNT_MAX) ? hit_cnt_r + CNT_W'(1) : hit_cnt_r;
    acc_cnt_nxt = (acc_cnt_r != CNT_MAX) ? acc_cnt_r + CNT_W'(1) : acc_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      acc_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else if (fire) begin
      hit_cnt_r   <= hit_cnt_nxt;
      acc_cnt_r   <= acc_cnt_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      hit_r      <= hit_c;
      evicted_r  <= evict_c;
      way_used_r <= USED_W'(victim);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hit          = hit_r;
  assign out_ch.way_used     = way_used_r;
  assign out_ch.evicted      = evicted_r;
  assign out_ch.hit_total    = hit_cnt_r;
  assign out_ch.access_total = acc_cnt_r;

endmodule

### rtl/sacl_chk.sv
`timescale 1ns / 1ps
`include "set_assoc_cache_lru_hit_counter_assert.svh"
module sacl_chk import sacl_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             hit,
  input logic             evicted,
  input logic [CNT_W-1:0] hit_total,
  input logic [CNT_W-1:0] access_total
);

  `SACL_AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(access_total), "result dropped or changed while stalled")
  `SACL_AST_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second item taken while one is in flight")
  `SACL_AST_NOW(a_hit_no_evict, out_valid, !(hit && evicted), "hit reported together with eviction")
  `SACL_AST_NOW(a_hits_le_acc, out_valid, hit_total <= access_total, "hit total exceeds access total")
  `SACL_AST_RST(a_rst_clear, !rst_n, !out_valid, "result valid after reset")

endmodule

bind set_assoc_cache_lru_hit_counter sacl_chk u_sacl_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .hit          (out_ch.hit),
  .evicted      (out_ch.evicted),
  .hit_total    (out_ch.hit_total),
  .access_total (out_ch.access_total)
);

### tb/tb_set_assoc_cache_lru_hit_counter.sv
`timescale 1ns / 1ps
module tb_set_assoc_cache_lru_hit_counter import sacl_pkg::*;;

  typedef struct packed {
    logic              hit;
    logic [USED_W-1:0] way;
    logic              evicted;
    logic [CNT_W-1:0]  hits;
    logic [CNT_W-1:0]  accesses;
  } access_res_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              typed;
    access_res_t       res;
  } dir_row_t;

  localparam int N_DIR    = 21;
  localparam int N_RAND   = 2000;
  localparam int HOLD_LEN = 200;

  logic clk;
  logic rst_n;

  sacl_in_if  in_ch ();
  sacl_out_if out_ch ();

  set_assoc_cache_lru_hit_counter u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow cache state
  tag_t             cache_tags  [SETS][WAYS];
  bit               cache_valid [SETS][WAYS];
  int unsigned      cache_age   [SETS][WAYS];
  logic [CNT_W-1:0] model_hits;
  logic [CNT_W-1:0] model_accesses;

  access_res_t pending_results [$];

  int  errors         = 0;
  int  items_sent;
  int  hits_seen      = 0;
  int  evictions_seen = 0;
  int  results_seen   = 0;
  bit  calm;
  bit  hold_done      = 1'b0;
  int  hold_cnt       = 0;

  // First rows carry hand-derived results; the rest rely on the shadow cache.
  dir_row_t dir_rows [N_DIR] = '{
    '{32'h0000_0000, 1'b1, '{1'b0, 2'd0, 1'b0, 32'd0, 32'd1}},
    '{32'h0000_000F, 1'b1, '{1'b1, 2'd0, 1'b0, 32'd1, 32'd2}},
    '{32'hFFFF_FFFF, 1'b1, '{1'b0, 2'd0, 1'b0, 32'd1, 32'd3}},
    '{32'h0000_0400, 1'b1, '{1'b0, 2'd1, 1'b0, 32'd1, 32'd4}},
    '{32'h0000_0800, 1'b1, '{1'b0, 2'd2, 1'b0, 32'd1, 32'd5}},
    '{32'h0000_0C00, 1'b1, '{1'b0, 2'd3, 1'b0, 32'd1, 32'd6}},
    '{32'h0000_1000, 1'b1, '{1'b0, 2'd0, 1'b1, 32'd1, 32'd7}},
    '{32'h0000_0000, 1'b0, '0},
    '{32'h0000_0404, 1'b0, '0},
    '{32'h0000_0C08, 1'b0, '0},
    '{32'hFFFF_FFF0, 1'b0, '0},
    '{32'h8000_0000, 1'b0, '0},
    '{32'h7FFF_FFFF, 1'b0, '0},
    '{32'hAAAA_AAAA, 1'b0, '0},
    '{32'h5555_5555, 1'b0, '0},
    '{32'h0000_03F0, 1'b0, '0},
    '{32'hFFFF_FC00, 1'b0, '0},
    '{32'h0000_1000, 1'b0, '0},
    '{32'h0000_FFFF, 1'b0, '0},
    '{32'hFFFF_0000, 1'b0, '0},
    '{32'h1234_5678, 1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic access_res_t cache_access(input logic [ADDR_W-1:0] addr);
    access_res_t r;
    int          set_idx;
    tag_t        tg;
    int          found;
    int          free;
    int          pick;
    bit          was_valid;
    int unsigned old;
    r       = '0;
    set_idx = int'((addr >> OFF_BITS) & SET_MASK);
    if (set_idx >= SETS) set_idx = 0;
    tg    = tag_t'(addr >> TAG_SHIFT);
    found = WAYS;
    free  = WAYS;
    for (int w = 0; w < WAYS; w++) begin
      if (cache_valid[set_idx][w]) begin
        if (found == WAYS && cache_tags[set_idx][w] == tg) found = w;
      end else if (free == WAYS) begin
        free = w;
      end
    end
    if (found != WAYS) begin
      r.hit     = 1'b1;
      pick      = found;
      was_valid = 1'b1;
    end else if (free != WAYS) begin
      pick      = free;
      was_valid = 1'b0;
      cache_tags[set_idx][pick] = tg;
    end else begin
      // victim: lowest way among those with the oldest age
      pick = 0;
      for (int w = 1; w < WAYS; w++)
        if (cache_age[set_idx][w] > cache_age[set_idx][pick]) pick = w;
      r.evicted = 1'b1;
      was_valid = 1'b1;
      cache_tags[set_idx][pick] = tg;
    end
    old = cache_age[set_idx][pick];
    for (int w = 0; w < WAYS; w++) begin
      if (w != pick && cache_valid[set_idx][w] &&
          (!was_valid || cache_age[set_idx][w] < old))
        cache_age[set_idx][w] = cache_age[set_idx][w] + 1;
    end
    cache_age[set_idx][pick]   = 0;
    cache_valid[set_idx][pick] = 1'b1;
    if (r.hit && model_hits != CNT_MAX) model_hits = model_hits + CNT_W'(1);
    if (model_accesses != CNT_MAX) model_accesses = model_accesses + CNT_W'(1);
    r.way      = USED_W'(pick);
    r.hits     = model_hits;
    r.accesses = model_accesses;
    return r;
  endfunction

  task automatic send_address(input logic [ADDR_W-1:0] addr, input bit typed,
                              input access_res_t typed_res);
    access_res_t r;
    while (!calm && $urandom_range(0, 99) < 24) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.address <= addr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = cache_access(addr);
    if (typed) r = typed_res;
    pending_results = {pending_results, r};
    items_sent++;
  endtask

  // Result side: random stalls, one long hold-off while the sender keeps offering items
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_ch.ready <= 1'b0;
      hold_cnt     <= hold_cnt - 1;
    end else if (!hold_done && items_sent >= 300) begin
      out_ch.ready <= 1'b0;
      hold_cnt     <= HOLD_LEN;
      hold_done    <= 1'b1;
    end else begin
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 24);
    end
  end

  task automatic report(input string field, input logic [CNT_W-1:0] exp_v,
                        input logic [CNT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    access_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, hit=%0b way=%0d", $time, out_ch.hit,
                 out_ch.way_used);
        errors++;
      end else begin
        e = pending_results.pop_front();
        report("hit",          CNT_W'(e.hit),      CNT_W'(out_ch.hit));
        report("way_used",     CNT_W'(e.way),      CNT_W'(out_ch.way_used));
        report("evicted",      CNT_W'(e.evicted),  CNT_W'(out_ch.evicted));
        report("hit_total",    e.hits,             out_ch.hit_total);
        report("access_total", e.accesses,         out_ch.access_total);
        if (out_ch.hit) hits_seen++;
        if (out_ch.evicted) evictions_seen++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    tag_t              tag_pool [8];
    logic [ADDR_W-1:0] recent [$];
    logic [ADDR_W-1:0] addr;
    int                mode;
    tag_t              tg;
    logic [ADDR_W-1:0] set_sel;
    int                wait_cnt;

    items_sent     = 0;
    calm           = 1'b0;
    model_hits     = '0;
    model_accesses = '0;
    for (int s = 0; s < SETS; s++)
      for (int w = 0; w < WAYS; w++) begin
        cache_tags[s][w]  = '0;
        cache_valid[s][w] = 1'b0;
        cache_age[s][w]   = 0;
      end

    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.address <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_address(dir_rows[i].addr, dir_rows[i].typed, dir_rows[i].res);

    // Small tag pool over a few sets keeps hits and LRU evictions frequent
    foreach (tag_pool[i]) tag_pool[i] = tag_t'($urandom);
    for (int n = 0; n < N_RAND; n++) begin
      calm = (n >= 800 && n < 1100);
      mode = $urandom_range(0, 9);
      if (mode <= 5) begin
        tg      = tag_pool[$urandom_range(0, 7)];
        set_sel = ADDR_W'($urandom_range(0, 3));
        addr    = (ADDR_W'(tg) << TAG_SHIFT) | (set_sel << OFF_BITS) |
                  (ADDR_W'($urandom) & ((ADDR_W'(1) << OFF_BITS) - ADDR_W'(1)));
      end else if (mode <= 7 || recent.size() == 0) begin
        addr = $urandom;
      end else begin
        addr = recent[$urandom_range(0, recent.size() - 1)];
      end
      recent = {recent, addr};
      if (recent.size() > 16) void'(recent.pop_front());
      send_address(addr, 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    wait_cnt = 0;
    while (wait_cnt < 20) begin
      @(posedge clk);
      wait_cnt++;
    end

    $display("tb: %0d accesses checked (%0d directed), %0d hits, %0d LRU evictions",
             results_seen, N_DIR, hits_seen, evictions_seen);
    $display("tb: random mix of pooled tags, repeats and full-range addresses, with stalls");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
